@@ src/krt_pkg.sv @@
package krt_pkg;

	localparam int FUNC_W   = 2;
	localparam int KEY_W    = 37;
	localparam int PAY_W    = 64;
	localparam int RIDX_W   = 4;
	localparam int STATUS_W = 2;
	localparam int IDX_W    = 4;
	localparam int CNT_W    = 5;

	localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd3;

	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} entry_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic load;   // append writes this cell
		logic shift;  // whole row moves one place toward cell 0
		logic tail;   // this cell takes the head entry back in
	} cell_ctl_t;

endpackage

@@ src/krt_in_if.sv @@
interface krt_in_if
	import krt_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [KEY_W-1:0]    key;
	logic [PAY_W-1:0]    payload;
	logic [RIDX_W-1:0]   read_index;

	modport source (output valid, func, key, payload, read_index, input ready);
	modport sink (input valid, func, key, payload, read_index, output ready);
endinterface

@@ src/krt_out_if.sv @@
interface krt_out_if
	import krt_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0]    found_index;
	logic [KEY_W-1:0]    key_out;
	logic [PAY_W-1:0]    payload_out;
	logic [CNT_W-1:0]    entry_count;

	modport source (output valid, status, found_index, key_out, payload_out, entry_count,
		input ready);
	modport sink (input valid, status, found_index, key_out, payload_out, entry_count,
		output ready);
endinterface

@@ src/krt_cell.sv @@
module krt_cell
	import krt_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  entry_t    load_data,
	input  entry_t    head,
	input  entry_t    nbr,
	output entry_t    data
);

	entry_t data_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= load_data;
		end else if (ctl.shift) begin
			data_q <= ctl.tail ? head : nbr;
		end
	end

	assign data = data_q;

endmodule

@@ src/keyed_record_table.sv @@
// channel | dir | payload                                             | transfer
// req     | in  | func, key, payload, read_index                      | valid & ready
// rsp     | out | status, found_index, key_out, payload_out, entry_count | valid & ready
//
// append: taken in S_IDLE, result goes from S_RESP to the output register once that is free
// delete, lookup, in-range read: one pass through the cell row (one entry leaves cell 0 per
// cycle and goes back in at the tail unless it is deleted), then S_RESP hands on the result;
// an empty table or a read past the last entry skips the pass and answers like append
// reset clears the fill count and the sequencer; entries are unknown until written
// a new request is taken while the last result waits in the output register, held until rsp.ready
module keyed_record_table
	import krt_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input logic     clk,
	input logic     arst_n,
	krt_in_if.sink  req,
	krt_out_if.source rsp
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > RIDX_W) ? CW : RIDX_W;

	typedef enum logic [1:0] {S_IDLE, S_PASS, S_RESP} state_t;

	state_t              state_q;
	logic [CW-1:0]       fill_q;
	logic [CW-1:0]       step_q;
	logic [CW-1:0]       pass_len_q;
	logic                hit_q;
	logic [FUNC_W-1:0]   op_q;
	logic [KEY_W-1:0]    key_q;
	logic [RIDX_W-1:0]   ridx_q;

	logic [STATUS_W-1:0] res_status_q;
	logic [IDX_W-1:0]    res_idx_q;
	logic [KEY_W-1:0]    res_key_q;
	logic [PAY_W-1:0]    res_pay_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [IDX_W-1:0]    out_idx_q;
	logic [KEY_W-1:0]    out_key_q;
	logic [PAY_W-1:0]    out_pay_q;
	logic [CNT_W-1:0]    out_cnt_q;

	logic   acc;
	logic   full;
	logic   app_go;
	logic   hit_now;
	logic   drop;
	logic   out_free;
	entry_t head;
	entry_t app_data;

	entry_t    cell_data [CAPACITY];
	cell_ctl_t cell_ctl  [CAPACITY];

	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign full      = (fill_q == CW'(CAPACITY));
	assign app_go    = acc && (req.func == FUNC_APPEND) && !full;
	assign head      = cell_data[0];
	assign out_free  = !out_valid_q || rsp.ready;

	always_comb begin
		app_data.key     = req.key;
		app_data.payload = req.payload;
	end

	// first hit of the pass: position match for read, key match otherwise
	always_comb begin
		hit_now = 1'b0;
		if (state_q == S_PASS && !hit_q) begin
			if (op_q == FUNC_READ) begin
				hit_now = (CMPW'(step_q) == CMPW'(ridx_q));
			end else begin
				hit_now = (head.key == key_q);
			end
		end
	end

	// a deleted entry leaves cell 0 and is not taken back in
	assign drop = hit_now && (op_q == FUNC_DELETE);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t nbr;

		always_comb begin
			cell_ctl[i].load  = app_go && (fill_q == CW'(i));
			cell_ctl[i].shift = (state_q == S_PASS);
			cell_ctl[i].tail  = !drop && (CW'(i + 1) == fill_q);
		end

		if (i == CAPACITY - 1) begin : g_last
			assign nbr = cell_data[0];
		end else begin : g_mid
			assign nbr = cell_data[i + 1];
		end

		krt_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl[i]),
			.load_data (app_data),
			.head      (head),
			.nbr       (nbr),
			.data      (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			step_q      <= '0;
			pass_len_q  <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						op_q         <= req.func;
						key_q        <= req.key;
						ridx_q       <= req.read_index;
						step_q       <= '0;
						pass_len_q   <= fill_q;
						hit_q        <= 1'b0;
						res_status_q <= STAT_NOTFOUND;
						res_idx_q    <= '0;
						res_key_q    <= '0;
						res_pay_q    <= '0;
						state_q      <= S_RESP;
						case (req.func)
							FUNC_APPEND: begin
								if (full) begin
									res_status_q <= STAT_FULL;
								end else begin
									res_status_q <= STAT_OK;
									res_idx_q    <= IDX_W'(fill_q);
									res_key_q    <= req.key;
									res_pay_q    <= req.payload;
									fill_q       <= fill_q + 1'b1;
								end
							end
							FUNC_DELETE: begin
								if (fill_q == '0) begin
									res_status_q <= STAT_EMPTY;
								end else begin
									state_q <= S_PASS;
								end
							end
							FUNC_LOOKUP: begin
								if (fill_q != '0) begin
									state_q <= S_PASS;
								end
							end
							default: begin
								if (fill_q == '0) begin
									res_status_q <= STAT_EMPTY;
								end else if (CMPW'(req.read_index) < CMPW'(fill_q)) begin
									state_q <= S_PASS;
								end
							end
						endcase
					end
				end
				S_PASS: begin
					step_q <= step_q + 1'b1;
					if (hit_now) begin
						hit_q        <= 1'b1;
						res_status_q <= STAT_OK;
						res_idx_q    <= IDX_W'(step_q);
						res_key_q    <= head.key;
						res_pay_q    <= head.payload;
					end
					if (drop) begin
						fill_q <= fill_q - 1'b1;
					end
					if (step_q == pass_len_q - 1'b1) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_idx_q    <= res_idx_q;
						out_key_q    <= res_key_q;
						out_pay_q    <= res_pay_q;
						out_cnt_q    <= CNT_W'(fill_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.found_index = out_idx_q;
	assign rsp.key_out     = out_key_q;
	assign rsp.payload_out = out_pay_q;
	assign rsp.entry_count = out_cnt_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PASS |-> step_q < pass_len_q)
		else $error("pass ran past the entry count");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		app_go |=> fill_q == CW'($past(fill_q) + 1'b1))
		else $error("append did not grow the table");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != STAT_OK |->
			out_idx_q == '0 && out_key_q == '0 && out_pay_q == '0)
		else $error("failed result carries entry data");

	a_single_drop: assert property (@(posedge clk) disable iff (!arst_n)
		drop |=> hit_q)
		else $error("delete hit not recorded");

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
	import krt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY    = 16;
	localparam int STALL_LIMIT = 4000;
	localparam int SHOW_LIMIT  = 10;
	localparam logic [63:0] KEY_SPAN = 64'd100000000000;
	localparam logic [KEY_W-1:0] KEY_TOP = KEY_W'(64'd99999999999);

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [KEY_W-1:0]  key;
		logic [PAY_W-1:0]  payload;
		logic [RIDX_W-1:0] ridx;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    idx;
		logic [KEY_W-1:0]    key;
		logic [PAY_W-1:0]    payload;
		logic [CNT_W-1:0]    count;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	krt_in_if  req_ch ();
	krt_out_if rsp_ch ();

	keyed_record_table #(.CAPACITY(CAPACITY)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #2 clk = ~clk;

	// shadow copy of the table contents
	logic [KEY_W-1:0] tbl_key [CAPACITY];
	logic [PAY_W-1:0] tbl_pay [CAPACITY];
	int               tbl_fill = 0;

	outcome_t pending_outcomes [$];
	int       fail_count = 0;
	int       shown = 0;
	int       op_seen [4] = '{default: 0};
	int       status_seen [4] = '{default: 0};
	int       send_idle_pct = 6;
	int       recv_idle_pct = 61;
	int       quiet_cycles = 0;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		logic [63:0] v;
		v = rand64() % KEY_SPAN;
		return v[KEY_W-1:0];
	endfunction

	function automatic outcome_t table_apply(request_t rq);
		outcome_t o;
		int       hit;
		hit = -1;
		o = '0;
		if (rq.func != FUNC_APPEND) begin
			for (int i = 0; i < tbl_fill; i++) begin
				if (hit < 0 && tbl_key[i] == rq.key)
					hit = i;
			end
		end
		case (rq.func)
			FUNC_APPEND: begin
				if (tbl_fill >= CAPACITY) begin
					o.status = STAT_FULL;
				end else begin
					tbl_key[tbl_fill] = rq.key;
					tbl_pay[tbl_fill] = rq.payload;
					o.status  = STAT_OK;
					o.idx     = IDX_W'(tbl_fill);
					o.key     = rq.key;
					o.payload = rq.payload;
					tbl_fill++;
				end
			end
			FUNC_DELETE: begin
				if (tbl_fill == 0) begin
					o.status = STAT_EMPTY;
				end else if (hit < 0) begin
					o.status = STAT_NOTFOUND;
				end else begin
					o.status  = STAT_OK;
					o.idx     = IDX_W'(hit);
					o.key     = tbl_key[hit];
					o.payload = tbl_pay[hit];
					for (int i = hit; i + 1 < tbl_fill; i++) begin
						tbl_key[i] = tbl_key[i + 1];
						tbl_pay[i] = tbl_pay[i + 1];
					end
					tbl_fill--;
				end
			end
			FUNC_LOOKUP: begin
				if (hit < 0) begin
					o.status = STAT_NOTFOUND;
				end else begin
					o.status  = STAT_OK;
					o.idx     = IDX_W'(hit);
					o.key     = tbl_key[hit];
					o.payload = tbl_pay[hit];
				end
			end
			default: begin
				if (tbl_fill == 0) begin
					o.status = STAT_EMPTY;
				end else if (int'(rq.ridx) >= tbl_fill) begin
					o.status = STAT_NOTFOUND;
				end else begin
					o.status  = STAT_OK;
					o.idx     = rq.ridx;
					o.key     = tbl_key[rq.ridx];
					o.payload = tbl_pay[rq.ridx];
				end
			end
		endcase
		o.count = CNT_W'(tbl_fill);
		op_seen[rq.func]++;
		status_seen[o.status]++;
		return o;
	endfunction

	task automatic issue_request(input request_t rq);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.func       <= rq.func;
		req_ch.key        <= rq.key;
		req_ch.payload    <= rq.payload;
		req_ch.read_index <= rq.ridx;
		do
			@(posedge clk);
		while (!req_ch.ready);
		pending_outcomes.push_back(table_apply(rq));
	endtask

	task automatic issue(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
		input logic [PAY_W-1:0] payload, input logic [RIDX_W-1:0] ridx);
		request_t rq;
		rq = '{func: func, key: key, payload: payload, ridx: ridx};
		issue_request(rq);
	endtask

	// hold the request side off until every outstanding result has come back
	task automatic drain_outcomes();
		req_ch.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_table();
		issue(FUNC_DELETE, 37'd5, rand64(), 4'd0);
		issue(FUNC_LOOKUP, '0, rand64(), 4'd0);
		issue(FUNC_READ, rand_key(), rand64(), 4'd0);
	endtask

	task automatic test_fill_and_overflow();
		logic [KEY_W-1:0] k;
		logic [PAY_W-1:0] p;
		for (int i = 0; i < CAPACITY; i++) begin
			case (i)
				0:       k = '0;
				1:       k = KEY_TOP;
				2:       k = KEY_W'(64'd1) << (KEY_W - 1);
				3, 9:    k = 37'd42;
				default: k = rand_key();
			endcase
			case (i)
				0:       p = '0;
				1:       p = '1;
				default: p = rand64();
			endcase
			issue(FUNC_APPEND, k, p, RIDX_W'($urandom_range(15)));
		end
		issue(FUNC_APPEND, rand_key(), rand64(), 4'd0);
	endtask

	task automatic test_search_and_remove();
		issue(FUNC_LOOKUP, 37'd42, '0, 4'd0);
		issue(FUNC_DELETE, 37'd12345, '0, 4'd0);
		issue(FUNC_DELETE, 37'd42, '0, 4'd0);
		issue(FUNC_DELETE, '0, '1, 4'd15);
		issue(FUNC_READ, '0, '0, 4'd15);
		issue(FUNC_READ, '1, '0, 4'd13);
	endtask

	task automatic test_random_traffic(input int items, input int send_pct, input int recv_pct);
		logic [KEY_W-1:0] key_pool [8];
		request_t         rq;
		int               target;
		int               r;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		target = CAPACITY / 2;
		foreach (key_pool[i])
			key_pool[i] = rand_key();
		key_pool[0] = '0;
		key_pool[1] = KEY_TOP;
		for (int n = 0; n < items; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(3))
					0:       target = 0;
					1:       target = CAPACITY;
					default: target = $urandom_range(CAPACITY);
				endcase
			end
			r = $urandom_range(99);
			rq.payload = rand64();
			rq.ridx    = RIDX_W'($urandom_range(15));
			rq.key     = rand_key();
			if (r < 5) begin
				// noise: any function, and any key up to KEY_TOP
				rq.func = FUNC_W'($urandom_range(3));
				rq.key  = KEY_W'(rand64());
				if (rq.key > KEY_TOP)
					rq.key = KEY_TOP;
			end else begin
				if (tbl_fill < target)
					rq.func = (r < 70) ? FUNC_APPEND : FUNC_W'($urandom_range(3));
				else if (tbl_fill > target)
					rq.func = (r < 55) ? FUNC_DELETE : FUNC_W'($urandom_range(3));
				else
					rq.func = FUNC_W'($urandom_range(3));
				r = $urandom_range(99);
				if (rq.func == FUNC_APPEND) begin
					if (r < 30 && tbl_fill > 0)
						rq.key = tbl_key[$urandom_range(tbl_fill - 1)];
					else if (r < 60)
						rq.key = key_pool[$urandom_range(7)];
					if ($urandom_range(19) == 0)
						rq.payload = ($urandom_range(1) != 0) ? '1 : '0;
				end else if (rq.func == FUNC_READ) begin
					if (r < 75 && tbl_fill > 0)
						rq.ridx = RIDX_W'($urandom_range(tbl_fill - 1));
				end else begin
					if (r < 75 && tbl_fill > 0)
						rq.key = tbl_key[$urandom_range(tbl_fill - 1)];
					else if (r < 88)
						rq.key = key_pool[$urandom_range(7)];
				end
			end
			issue_request(rq);
		end
		drain_outcomes();
	endtask

	// result sink with random back-pressure
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		outcome_t got, want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = '{status: rsp_ch.status, idx: rsp_ch.found_index, key: rsp_ch.key_out,
				payload: rsp_ch.payload_out, count: rsp_ch.entry_count};
			if (pending_outcomes.size() == 0) begin
				fail_count++;
				if (shown < SHOW_LIMIT) begin
					shown++;
					$display("unexpected result: status %0d idx %0d key %h payload %h count %0d",
						got.status, got.idx, got.key, got.payload, got.count);
				end
			end else begin
				want = pending_outcomes.pop_front();
				if (got !== want) begin
					fail_count++;
					if (shown < SHOW_LIMIT) begin
						shown++;
						$display("mismatch at %0t: expected status %0d idx %0d key %h payload %h count %0d",
							$realtime, want.status, want.idx, want.key, want.payload, want.count);
						$display("                 got      status %0d idx %0d key %h payload %h count %0d",
							got.status, got.idx, got.key, got.payload, got.count);
					end
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.func       <= FUNC_APPEND;
		req_ch.key        <= '0;
		req_ch.payload    <= '0;
		req_ch.read_index <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_fill_and_overflow();
		test_search_and_remove();
		drain_outcomes();

		test_random_traffic(400, 6, 61);
		test_random_traffic(400, 61, 6);
		test_random_traffic(400, 0, 0);

		repeat (40) @(posedge clk);
		if (pending_outcomes.size() != 0) begin
			$display("%0d expected results never arrived", pending_outcomes.size());
			fail_count += pending_outcomes.size();
		end
		$display("covered %0d appends, %0d deletes, %0d lookups, %0d reads",
			op_seen[FUNC_APPEND], op_seen[FUNC_DELETE], op_seen[FUNC_LOOKUP], op_seen[FUNC_READ]);
		$display("outcomes: %0d ok, %0d empty, %0d not found, %0d full; %0d failures",
			status_seen[STAT_OK], status_seen[STAT_EMPTY], status_seen[STAT_NOTFOUND],
			status_seen[STAT_FULL], fail_count);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
